// File: rtl/core/table_interpolation_evaluator_core_macros.svh
// Assertion helpers for the core's sequencer.
`ifndef TABLE_INTERPOLATION_EVALUATOR_CORE_MACROS_SVH
`define TABLE_INTERPOLATION_EVALUATOR_CORE_MACROS_SVH

// Same-cycle implication.
`define TIE_ASSERT_IMP(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("tie assertion failed");

// Next-cycle implication.
`define TIE_ASSERT_NXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("tie assertion failed");

`endif

// File: rtl/core/tie_pkg.sv
package tie_pkg;

    localparam int DEFAULT_TABLE_DEPTH = 256;
    localparam int Q_W        = 32;
    localparam int IDX_W      = 8;
    localparam int STATUS_W   = 2;
    localparam int COUNT_W    = 9;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 9;
    localparam int P_W        = 65;    // |dy| * |dz| fits 65 bits
    localparam int DIV_STEPS  = P_W;   // one quotient bit per step
    localparam int DIV_CNT_W  = $clog2(DIV_STEPS);

    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_EVAL  = 1'b1;

    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_BELOW = 2'd1;
    localparam logic [STATUS_W-1:0] ST_ABOVE = 2'd2;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd3;

    localparam logic [CFG_IDX_W-1:0] REG_EVAL_MODE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ENTRY_COUNT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_USE_HINT    = 2'd2;

    typedef enum logic [3:0] {
        DP_NOP,
        DP_LD1,
        DP_LD2,
        DP_DIFF,
        DP_MUL0,
        DP_MUL1,
        DP_DIV_STEP,
        DP_ROUND,
        DP_LERP_RES,
        DP_RES_Y1,
        DP_RES_V,
        DP_H_MUL,
        DP_H_ADD
    } dp_op_t;

    typedef struct packed {
        logic                start;
        logic                wr_en;
        dp_op_t              op;
        logic                out_load;
        logic [IDX_W-1:0]    out_idx;
        logic [STATUS_W-1:0] out_status;
    } dp_cmd_t;

    typedef struct packed {
        logic z_ge_key;
        logic z_gt_key;
        logic dx_zero;
    } dp_stat_t;

endpackage

// File: rtl/core/tie_ram.sv
module tie_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// File: rtl/core/tie_datapath.sv
module tie_datapath import tie_pkg::*; #(
    parameter int TABLE_DEPTH = DEFAULT_TABLE_DEPTH,
    localparam int IW = $clog2(TABLE_DEPTH)
) (
    input  logic                    aclk,
    input  dp_cmd_t                 cmd,
    input  logic [IW-1:0]           raddr,
    input  logic [IDX_W-1:0]        entry_index,
    input  logic signed [Q_W-1:0]   entry_key,
    input  logic signed [Q_W-1:0]   entry_value,
    input  logic signed [Q_W-1:0]   query_point,
    output dp_stat_t                stat,
    output logic signed [Q_W-1:0]   result_value,
    output logic [IDX_W-1:0]        interval_index,
    output logic [STATUS_W-1:0]     status
);

    logic            we;
    logic [Q_W-1:0]  key_rd;
    logic [Q_W-1:0]  val_rd;

    logic signed [Q_W-1:0] z_reg, x1_reg, y1_reg, x2_reg, y2_reg, acc_reg, res_reg;
    logic signed [63:0]    prod_reg;
    logic [32:0]           ax_reg, ay_reg, az_reg;
    logic                  neg_reg, dx_zero_reg;
    logic [P_W-1:0]        p_reg;
    logic [32:0]           rem_reg;
    logic signed [Q_W-1:0] out_val_reg;
    logic [IDX_W-1:0]      out_idx_reg;
    logic [STATUS_W-1:0]   out_st_reg;

    logic signed [32:0] dx, dy, dz;
    logic [49:0]        pp0;
    logic [48:0]        pp1;
    logic [33:0]        trial;
    logic               q_bit;
    logic               rnd_up;
    logic signed [48:0] lsum;
    logic signed [63:0] pr;
    logic signed [48:0] hsum;

    function automatic logic [Q_W-1:0] sat32(input logic signed [48:0] v);
        if (v > 49'sd2147483647) begin
            return 32'h7FFF_FFFF;
        end else if (v < -49'sd2147483648) begin
            return 32'h8000_0000;
        end
        return v[31:0];
    endfunction

    assign we = cmd.wr_en && (32'(entry_index) < TABLE_DEPTH);

    tie_ram #(.WIDTH(Q_W), .DEPTH(TABLE_DEPTH)) u_key_ram (
        .aclk  (aclk),
        .we    (we),
        .waddr (IW'(entry_index)),
        .wdata (entry_key),
        .raddr (raddr),
        .rdata (key_rd)
    );

    tie_ram #(.WIDTH(Q_W), .DEPTH(TABLE_DEPTH)) u_val_ram (
        .aclk  (aclk),
        .we    (we),
        .waddr (IW'(entry_index)),
        .wdata (entry_value),
        .raddr (raddr),
        .rdata (val_rd)
    );

    always_comb begin
        dx     = {x2_reg[31], x2_reg} - {x1_reg[31], x1_reg};
        dy     = {y2_reg[31], y2_reg} - {y1_reg[31], y1_reg};
        dz     = {z_reg[31], z_reg} - {x1_reg[31], x1_reg};
        pp0    = ay_reg * az_reg[16:0];
        pp1    = ay_reg * az_reg[32:17];
        trial  = {rem_reg, p_reg[P_W-1]};
        q_bit  = trial >= {1'b0, ax_reg};
        rnd_up = {rem_reg, 1'b0} >= {1'b0, ax_reg};
        lsum   = neg_reg ? ({{17{y1_reg[31]}}, y1_reg} - {16'd0, p_reg[32:0]})
                         : ({{17{y1_reg[31]}}, y1_reg} + {16'd0, p_reg[32:0]});
        pr     = prod_reg + 64'sd32768;
        hsum   = {pr[63], pr[63:16]} + {{17{key_rd[31]}}, key_rd};
    end

    always_ff @(posedge aclk) begin
        if (cmd.start) begin
            z_reg   <= query_point;
            res_reg <= '0;
            acc_reg <= '0;
        end
        case (cmd.op)
            DP_LD1: begin
                x1_reg <= key_rd;
                y1_reg <= val_rd;
            end
            DP_LD2: begin
                x2_reg <= key_rd;
                y2_reg <= val_rd;
            end
            DP_DIFF: begin
                ax_reg      <= dx[32] ? 33'(-dx) : 33'(dx);
                ay_reg      <= dy[32] ? 33'(-dy) : 33'(dy);
                az_reg      <= dz[32] ? 33'(-dz) : 33'(dz);
                neg_reg     <= dx[32] ^ dy[32] ^ dz[32];
                dx_zero_reg <= (dx == '0);
            end
            DP_MUL0: begin
                p_reg   <= P_W'(pp0);
                rem_reg <= '0;
            end
            DP_MUL1: p_reg <= p_reg + P_W'({pp1, 17'd0});
            DP_DIV_STEP: begin
                rem_reg <= q_bit ? 33'(trial - {1'b0, ax_reg}) : trial[32:0];
                p_reg   <= {p_reg[P_W-2:0], q_bit};
            end
            DP_ROUND: begin
                if (rnd_up) begin
                    p_reg <= p_reg + P_W'(1);
                end
            end
            DP_LERP_RES: begin
                if (|p_reg[P_W-1:33]) begin
                    res_reg <= neg_reg ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
                end else begin
                    res_reg <= sat32(lsum);
                end
            end
            DP_RES_Y1: res_reg <= y1_reg;
            DP_RES_V:  res_reg <= val_rd;
            DP_H_MUL:  prod_reg <= acc_reg * z_reg;
            DP_H_ADD: begin
                acc_reg <= sat32(hsum);
                res_reg <= sat32(hsum);
            end
            default: ;
        endcase
        if (cmd.out_load) begin
            out_val_reg <= res_reg;
            out_idx_reg <= cmd.out_idx;
            out_st_reg  <= cmd.out_status;
        end
    end

    assign stat.z_ge_key  = z_reg >= $signed(key_rd);
    assign stat.z_gt_key  = z_reg > $signed(key_rd);
    assign stat.dx_zero   = dx_zero_reg;
    assign result_value   = out_val_reg;
    assign interval_index = out_idx_reg;
    assign status         = out_st_reg;

endmodule

// File: rtl/core/tie_ctrl.sv
`include "table_interpolation_evaluator_core_macros.svh"

module tie_ctrl import tie_pkg::*; #(
    parameter int TABLE_DEPTH = DEFAULT_TABLE_DEPTH,
    localparam int IW = $clog2(TABLE_DEPTH)
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic                  s_command,
    output logic                  m_valid,
    input  logic                  m_ready,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  dp_stat_t              stat,
    output dp_cmd_t               dp_cmd,
    output logic [IW-1:0]         raddr
);

    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam int SW = CW + 1;

    typedef enum logic [4:0] {
        S_IDLE, S_R0_W, S_R0_U, S_RN_W, S_RN_U, S_ONE_W, S_ONE_U,
        S_HH_W, S_HH_U, S_HUP_CHK, S_HUP_W, S_HUP_U, S_HDN_CHK, S_HDN_W, S_HDN_U,
        S_BS_CHK, S_BS_W, S_BS_U, S_L0_W, S_L0_U, S_L1_W, S_L1_U,
        S_DIFF, S_MUL0, S_MUL1, S_DIV, S_RND, S_LRES, S_H_MUL, S_H_ADD, S_DONE
    } state_t;

    state_t               state_reg, state_next;
    logic [IW-1:0]        raddr_reg, raddr_next;
    logic [CW-1:0]        lo_reg, lo_next, hi_reg, hi_next;
    logic [CW-1:0]        a_reg, a_next, b_reg, b_next, m_reg, m_next;
    logic [CW-1:0]        k_reg, k_next, idx_reg, idx_next;
    logic [SW-1:0]        step_reg, step_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic [STATUS_W-1:0]  st_reg, st_next;
    logic [IW-1:0]        last_reg, last_next;
    logic                 eval_mode_reg, use_hint_reg;
    logic [COUNT_W-1:0]   count_reg;
    logic                 m_valid_reg, m_valid_next;

    logic [CW-1:0] n, nm1, nm2, hint, mid, am1, clamped;
    logic [SW-1:0] step2, up_sum;

    always_comb begin
        n       = (32'(count_reg) > TABLE_DEPTH) ? CW'(TABLE_DEPTH) : CW'(count_reg);
        nm1     = n - CW'(1);
        nm2     = n - CW'(2);
        hint    = (CW'(last_reg) > nm2) ? nm2 : CW'(last_reg);
        mid     = a_reg + ((b_reg - a_reg) >> 1);
        am1     = a_reg - CW'(1);
        clamped = (a_reg == '0) ? '0 : ((am1 > nm2) ? nm2 : am1);
        step2   = step_reg << 1;
        up_sum  = SW'(hi_reg) + step2;
    end

    always_comb begin
        state_next   = state_reg;
        raddr_next   = raddr_reg;
        lo_next      = lo_reg;
        hi_next      = hi_reg;
        a_next       = a_reg;
        b_next       = b_reg;
        m_next       = m_reg;
        k_next       = k_reg;
        idx_next     = idx_reg;
        step_next    = step_reg;
        cnt_next     = cnt_reg;
        st_next      = st_reg;
        last_next    = last_reg;
        m_valid_next = m_valid_reg;
        dp_cmd       = '{start: 1'b0, wr_en: 1'b0, op: DP_NOP, out_load: 1'b0,
                         out_idx: IDX_W'(idx_reg), out_status: st_reg};

        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    dp_cmd.start = 1'b1;
                    idx_next     = '0;
                    st_next      = ST_OK;
                    if (s_command == CMD_WRITE) begin
                        dp_cmd.wr_en = 1'b1;
                        state_next   = S_DONE;
                    end else if (n == '0) begin
                        st_next    = ST_EMPTY;
                        state_next = S_DONE;
                    end else if (eval_mode_reg) begin
                        k_next     = nm1;
                        raddr_next = IW'(nm1);
                        state_next = S_H_MUL;
                    end else begin
                        raddr_next = '0;
                        state_next = S_R0_W;
                    end
                end
            end
            S_R0_W: state_next = S_R0_U;
            S_R0_U: begin
                if (!stat.z_ge_key) begin
                    st_next    = ST_BELOW;
                    state_next = S_DONE;
                end else begin
                    raddr_next = IW'(nm1);
                    state_next = S_RN_W;
                end
            end
            S_RN_W: state_next = S_RN_U;
            S_RN_U: begin
                if (stat.z_gt_key) begin
                    st_next    = ST_ABOVE;
                    state_next = S_DONE;
                end else if (n == CW'(1)) begin
                    raddr_next = '0;
                    state_next = S_ONE_W;
                end else if (use_hint_reg) begin
                    m_next     = hint;
                    raddr_next = IW'(hint);
                    state_next = S_HH_W;
                end else begin
                    a_next     = '0;
                    b_next     = n;
                    state_next = S_BS_CHK;
                end
            end
            S_ONE_W: state_next = S_ONE_U;
            S_ONE_U: begin
                dp_cmd.op  = DP_RES_V;
                state_next = S_DONE;
            end
            S_HH_W: state_next = S_HH_U;
            S_HH_U: begin
                step_next = SW'(1);
                if (stat.z_ge_key) begin
                    lo_next    = m_reg;
                    hi_next    = m_reg + CW'(1);
                    state_next = S_HUP_CHK;
                end else begin
                    hi_next    = m_reg;
                    lo_next    = m_reg - CW'(1);
                    state_next = S_HDN_CHK;
                end
            end
            S_HUP_CHK: begin
                if (hi_reg < n) begin
                    raddr_next = IW'(hi_reg);
                    state_next = S_HUP_W;
                end else begin
                    a_next     = lo_reg + CW'(1);
                    b_next     = hi_reg;
                    state_next = S_BS_CHK;
                end
            end
            S_HUP_W: state_next = S_HUP_U;
            S_HUP_U: begin
                if (stat.z_ge_key) begin
                    lo_next    = hi_reg;
                    step_next  = step2;
                    hi_next    = (up_sum > SW'(n)) ? n : CW'(up_sum);
                    state_next = S_HUP_CHK;
                end else begin
                    a_next     = lo_reg + CW'(1);
                    b_next     = hi_reg;
                    state_next = S_BS_CHK;
                end
            end
            S_HDN_CHK: begin
                if (lo_reg != '0) begin
                    raddr_next = IW'(lo_reg);
                    state_next = S_HDN_W;
                end else begin
                    a_next     = lo_reg + CW'(1);
                    b_next     = hi_reg;
                    state_next = S_BS_CHK;
                end
            end
            S_HDN_W: state_next = S_HDN_U;
            S_HDN_U: begin
                if (!stat.z_ge_key) begin
                    hi_next    = lo_reg;
                    step_next  = step2;
                    lo_next    = (SW'(lo_reg) >= step2) ? CW'(SW'(lo_reg) - step2) : '0;
                    state_next = S_HDN_CHK;
                end else begin
                    a_next     = lo_reg + CW'(1);
                    b_next     = hi_reg;
                    state_next = S_BS_CHK;
                end
            end
            S_BS_CHK: begin
                if (a_reg < b_reg) begin
                    m_next     = mid;
                    raddr_next = IW'(mid);
                    state_next = S_BS_W;
                end else begin
                    idx_next   = clamped;
                    raddr_next = IW'(clamped);
                    if (use_hint_reg) begin
                        last_next = IW'(clamped);
                    end
                    state_next = S_L0_W;
                end
            end
            S_BS_W: state_next = S_BS_U;
            S_BS_U: begin
                if (!stat.z_ge_key) begin
                    b_next = m_reg;
                end else begin
                    a_next = m_reg + CW'(1);
                end
                state_next = S_BS_CHK;
            end
            S_L0_W: state_next = S_L0_U;
            S_L0_U: begin
                dp_cmd.op  = DP_LD1;
                raddr_next = IW'(idx_reg + CW'(1));
                state_next = S_L1_W;
            end
            S_L1_W: state_next = S_L1_U;
            S_L1_U: begin
                dp_cmd.op  = DP_LD2;
                state_next = S_DIFF;
            end
            S_DIFF: begin
                dp_cmd.op  = DP_DIFF;
                state_next = S_MUL0;
            end
            S_MUL0: begin
                if (stat.dx_zero) begin
                    dp_cmd.op  = DP_RES_Y1;
                    state_next = S_DONE;
                end else begin
                    dp_cmd.op  = DP_MUL0;
                    state_next = S_MUL1;
                end
            end
            S_MUL1: begin
                dp_cmd.op  = DP_MUL1;
                cnt_next   = '0;
                state_next = S_DIV;
            end
            S_DIV: begin
                dp_cmd.op = DP_DIV_STEP;
                cnt_next  = cnt_reg + DIV_CNT_W'(1);
                if (cnt_reg == DIV_CNT_W'(DIV_STEPS - 1)) begin
                    state_next = S_RND;
                end
            end
            S_RND: begin
                dp_cmd.op  = DP_ROUND;
                state_next = S_LRES;
            end
            S_LRES: begin
                dp_cmd.op  = DP_LERP_RES;
                state_next = S_DONE;
            end
            S_H_MUL: begin
                dp_cmd.op  = DP_H_MUL;
                state_next = S_H_ADD;
            end
            S_H_ADD: begin
                dp_cmd.op = DP_H_ADD;
                if (k_reg == '0) begin
                    state_next = S_DONE;
                end else begin
                    k_next     = k_reg - CW'(1);
                    raddr_next = IW'(k_reg - CW'(1));
                    state_next = S_H_MUL;
                end
            end
            S_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    dp_cmd.out_load = 1'b1;
                    state_next      = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase

        if (dp_cmd.out_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            m_valid_reg   <= 1'b0;
            last_reg      <= '0;
            eval_mode_reg <= 1'b0;
            count_reg     <= '0;
            use_hint_reg  <= 1'b1;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            last_reg    <= last_next;
            if (cfg_valid) begin
                unique case (cfg_index)
                    REG_EVAL_MODE:   eval_mode_reg <= cfg_data[0];
                    REG_ENTRY_COUNT: count_reg     <= cfg_data[COUNT_W-1:0];
                    REG_USE_HINT:    use_hint_reg  <= cfg_data[0];
                    default: ;
                endcase
            end
        end
        raddr_reg <= raddr_next;
        lo_reg    <= lo_next;
        hi_reg    <= hi_next;
        a_reg     <= a_next;
        b_reg     <= b_next;
        m_reg     <= m_next;
        k_reg     <= k_next;
        idx_reg   <= idx_next;
        step_reg  <= step_next;
        cnt_reg   <= cnt_next;
        st_reg    <= st_next;
    end

    assign s_ready   = (state_reg == S_IDLE);
    assign m_valid   = m_valid_reg;
    assign cfg_ready = 1'b1;
    assign raddr     = raddr_reg;

    `TIE_ASSERT_IMP(a_out_no_overrun, aclk, aresetn, dp_cmd.out_load, !m_valid_reg || m_ready)
    `TIE_ASSERT_NXT(a_accept_busy, aclk, aresetn, s_valid && state_reg == S_IDLE, state_reg != S_IDLE)
    `TIE_ASSERT_IMP(a_div_bound, aclk, aresetn, state_reg == S_DIV, 32'(cnt_reg) < DIV_STEPS)
    `TIE_ASSERT_IMP(a_hint_clamped, aclk, aresetn, state_reg == S_HH_U, m_reg <= nm2)

endmodule

// File: rtl/core/table_interpolation_evaluator_core.sv
// Channel   Dir   Handshake            Payload
// s_        in    s_valid / s_ready    command, entry index, key, value, query point
// m_        out   m_valid / m_ready    result value, interval index, status
// cfg_      in    cfg_valid/cfg_ready  register index, write data
//
// One word at a time. A write or an empty table goes straight to the output step; a point
// below or above the keys ends after its range check, a single-entry table after its read.
// Linear: range checks, hint read, then hunt and bisection probes and the search exit, then
// load and difference the operands, multiply, divide with the restoring divider, round and
// saturate, output; a zero-width interval leaves after the difference step. Polynomial: a
// multiply and an add per coefficient (Horner).
// Reset (aresetn low, synchronous) clears state, mode, count and hint and turns hint use on; tables stay unwritten.
// A new word is taken while the last result waits in the output register; a stalled
// result holds the sequencer in its final state until m_ready.
module table_interpolation_evaluator_core import tie_pkg::*; #(
    parameter int TABLE_DEPTH = DEFAULT_TABLE_DEPTH
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic                  s_command,
    input  logic [IDX_W-1:0]      s_entry_index,
    input  logic signed [Q_W-1:0] s_entry_key,
    input  logic signed [Q_W-1:0] s_entry_value,
    input  logic signed [Q_W-1:0] s_query_point,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic signed [Q_W-1:0] m_result_value,
    output logic [IDX_W-1:0]      m_interval_index,
    output logic [STATUS_W-1:0]   m_status,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int IW = $clog2(TABLE_DEPTH);

    dp_cmd_t       dp_cmd;
    dp_stat_t      dp_stat;
    logic [IW-1:0] raddr;

    // sequencer: range checks, hunt, bisection, Horner and divider counts
    tie_ctrl #(.TABLE_DEPTH(TABLE_DEPTH)) u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_command (s_command),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .stat      (dp_stat),
        .dp_cmd    (dp_cmd),
        .raddr     (raddr)
    );

    // tables, key compare, split multiplier, divider, saturation, output register
    tie_datapath #(.TABLE_DEPTH(TABLE_DEPTH)) u_datapath (
        .aclk           (aclk),
        .cmd            (dp_cmd),
        .raddr          (raddr),
        .entry_index    (s_entry_index),
        .entry_key      (s_entry_key),
        .entry_value    (s_entry_value),
        .query_point    (s_query_point),
        .stat           (dp_stat),
        .result_value   (m_result_value),
        .interval_index (m_interval_index),
        .status         (m_status)
    );

endmodule

// File: tb/sv/tb_table_interpolation_evaluator_core.sv
`timescale 1ns / 1ps

module tb_table_interpolation_evaluator_core;
    import tie_pkg::*;

    // Index with no register behind it; writes to it must be ignored
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
    localparam logic signed [Q_W-1:0] ONE_Q16 = 32'sh0001_0000;
    localparam int NUM_ITEMS = 1650;

    logic                  aclk;
    logic                  aresetn;
    logic                  s_valid;
    logic                  s_ready;
    logic                  s_command;
    logic [IDX_W-1:0]      s_entry_index;
    logic signed [Q_W-1:0] s_entry_key;
    logic signed [Q_W-1:0] s_entry_value;
    logic signed [Q_W-1:0] s_query_point;
    logic                  m_valid;
    logic                  m_ready;
    logic signed [Q_W-1:0] m_result_value;
    logic [IDX_W-1:0]      m_interval_index;
    logic [STATUS_W-1:0]   m_status;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    table_interpolation_evaluator_core uut (.*);

    // Clock: 10 ns period
    always begin
        aclk = 1'b1;
        #5;
        aclk = 1'b0;
        #5;
    end

    // ------------------------------------------------------------------
    // Predictor: local copy of tables, registers and search hint
    // ------------------------------------------------------------------
    typedef struct {
        logic signed [Q_W-1:0] value;
        logic [IDX_W-1:0]      interval;
        logic [STATUS_W-1:0]   status;
    } eval_word_t;

    logic signed [Q_W-1:0] key_mem [DEFAULT_TABLE_DEPTH];
    logic signed [Q_W-1:0] val_mem [DEFAULT_TABLE_DEPTH];
    int   hint_interval;
    logic poly_mode;
    int   count_reg;
    logic hint_on;

    eval_word_t awaiting_results [$];
    int errors;
    int items_sent;

    function automatic longint key_at(int i);
        return longint'(key_mem[i]);
    endfunction

    function automatic longint clamp_q(longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    // first slot in [a,b) whose key exceeds z, else b
    function automatic int first_above(int a, int b, longint z);
        int m;
        while (a < b) begin
            m = a + (b - a) / 2;
            if (key_at(m) > z) b = m;
            else a = m + 1;
        end
        return a;
    endfunction

    // galloping search outward from the last interval found
    function automatic int hunt_interval(int n, longint z);
        int h, lo, hi, stride;
        h = hint_interval;
        stride = 1;
        if (h > n - 2) h = n - 2;
        if (h < 0) h = 0;
        if (z >= key_at(h)) begin
            lo = h;
            hi = lo + 1;
            while (hi < n && z >= key_at(hi)) begin
                lo = hi;
                stride = stride << 1;
                hi = (lo + stride > n) ? n : lo + stride;
            end
        end else begin
            hi = h;
            lo = h - 1;
            while (lo > 0 && z < key_at(lo)) begin
                hi = lo;
                stride = stride << 1;
                lo = (lo >= stride) ? lo - stride : 0;
            end
        end
        return first_above(lo + 1, hi, z) - 1;
    endfunction

    function automatic longint interpolate(int i, longint z);
        longint x1, x2, y1, y2, dx, dy, dz;
        bit [63:0] ax, ay, az, p, q, r;
        bit neg;
        x1 = key_at(i);
        x2 = key_at(i + 1);
        y1 = longint'(val_mem[i]);
        y2 = longint'(val_mem[i + 1]);
        dx = x2 - x1;
        dy = y2 - y1;
        dz = z - x1;
        if (dx == 0) return y1;
        ax = (dx < 0) ? -dx : dx;
        ay = (dy < 0) ? -dy : dy;
        az = (dz < 0) ? -dz : dz;
        neg = ((dx < 0) != (dy < 0)) != (dz < 0);
        p = ay * az;
        q = p / ax;
        r = p % ax;
        if (r >= ax - r) q++;           // nearest, ties away from zero
        if (q > 64'h1_FFFF_FFFF) return neg ? -64'sd2147483648 : 64'sd2147483647;
        return clamp_q(neg ? y1 - longint'(q) : y1 + longint'(q));
    endfunction

    // Expected result of one word; updates the local state as the block would
    function automatic eval_word_t table_eval(logic cmd, logic [IDX_W-1:0] idx,
                                              logic signed [Q_W-1:0] k,
                                              logic signed [Q_W-1:0] v,
                                              logic signed [Q_W-1:0] q);
        eval_word_t w;
        int n, iv;
        longint z, acc;
        w.value = '0;
        w.interval = '0;
        w.status = ST_OK;
        n = (count_reg > DEFAULT_TABLE_DEPTH) ? DEFAULT_TABLE_DEPTH : count_reg;
        z = longint'(q);
        if (cmd == CMD_WRITE) begin
            key_mem[idx] = k;
            val_mem[idx] = v;
        end else if (n == 0) begin
            w.status = ST_EMPTY;
        end else if (poly_mode) begin
            acc = 0;
            for (int c = n - 1; c >= 0; c--)
                acc = clamp_q(((acc * z + 32768) >>> 16) + key_at(c));
            w.value = acc[Q_W-1:0];
        end else if (z < key_at(0)) begin
            w.status = ST_BELOW;
        end else if (z > key_at(n - 1)) begin
            w.status = ST_ABOVE;
        end else if (n == 1) begin
            w.value = val_mem[0];
        end else begin
            iv = hint_on ? hunt_interval(n, z) : first_above(0, n, z) - 1;
            if (iv < 0) iv = 0;
            if (iv > n - 2) iv = n - 2;
            if (hint_on) hint_interval = iv;
            acc = interpolate(iv, z);
            w.value = acc[Q_W-1:0];
            w.interval = iv[IDX_W-1:0];
        end
        return w;
    endfunction

    // ------------------------------------------------------------------
    // Sender side: bursts with random gaps
    // ------------------------------------------------------------------
    int burst_left;
    bit gaps_on;

    task automatic send_word(input logic cmd, input logic [IDX_W-1:0] idx,
                             input logic signed [Q_W-1:0] k,
                             input logic signed [Q_W-1:0] v,
                             input logic signed [Q_W-1:0] q);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 30);
            gap = gaps_on ? $urandom_range(0, 8) : 0;
            if (gap > 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        burst_left--;
        s_valid       <= 1'b1;
        s_command     <= cmd;
        s_entry_index <= idx;
        s_entry_key   <= k;
        s_entry_value <= v;
        s_query_point <= q;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        awaiting_results.push_back(table_eval(cmd, idx, k, v, q));
        items_sent++;
    endtask

    // unused fields carry random bits so every input bit toggles
    task automatic send_write(input int idx, input logic signed [Q_W-1:0] k,
                              input logic signed [Q_W-1:0] v);
        send_word(CMD_WRITE, idx[IDX_W-1:0], k, v, $urandom);
    endtask

    task automatic send_eval(input logic signed [Q_W-1:0] q);
        send_word(CMD_EVAL, IDX_W'($urandom), $urandom, $urandom, q);
    endtask

    // stop offering words and wait for every outstanding result
    task automatic drain;
        s_valid <= 1'b0;
        burst_left = 0;
        while (awaiting_results.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int data);
        drain();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data[CFG_DATA_W-1:0];
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
        case (idx)
            REG_EVAL_MODE:   poly_mode = data[0];
            REG_ENTRY_COUNT: count_reg = data & 9'h1FF;
            REG_USE_HINT:    hint_on = data[0];
            default: ;
        endcase
    endtask

    // Load slots 0..n-1. style 0: wide ascending keys, 1: tight keys with
    // repeats, 2: unordered noise, 3: small coefficients for Horner
    task automatic fill_table(input int n, input int style);
        longint k, stepmax;
        logic signed [Q_W-1:0] v;
        stepmax = 64'd4294967295 / n;
        if (style == 1)
            k = longint'($urandom_range(0, 32'hFFFF_FFFF - n * 16384)) - 64'sd2147483648;
        else
            k = longint'($urandom_range(0, stepmax)) - 64'sd2147483648;
        for (int i = 0; i < n; i++) begin
            v = ($urandom_range(0, 1) == 0) ? $urandom
                                            : $signed($urandom_range(0, 1 << 22)) - (1 << 21);
            case (style)
                2: send_write(i, $urandom, v);
                3: send_write(i, $signed($urandom_range(0, 1 << 19)) - (1 << 18), v);
                default: send_write(i, k[Q_W-1:0], v);
            endcase
            if (style == 1) k += $urandom_range(0, 4) * $urandom_range(0, 4096);
            else k += $urandom_range(0, stepmax);
        end
    endtask

    // mostly keys and points inside intervals, some outside and extremes
    function automatic logic signed [Q_W-1:0] pick_point(int n);
        int i, sel;
        longint lo, hi;
        bit [63:0] span;
        i = $urandom_range(0, n - 1);
        sel = $urandom_range(0, 9);
        lo = key_at(i);
        hi = (i < n - 1) ? key_at(i + 1) : lo;
        if (poly_mode)
            return (sel < 6) ? $signed($urandom_range(0, 1 << 19)) - (1 << 18) : $urandom;
        if (sel < 4) return key_mem[i];
        if (sel < 8 && hi > lo) begin
            span = hi - lo + 1;
            return Q_W'(lo + longint'({$urandom, $urandom} % span));
        end
        if (sel == 8) return ($urandom_range(0, 1) == 0) ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
        return $urandom;
    endfunction

    // ------------------------------------------------------------------
    // Receiver side: own stall pattern plus long hold-off on request
    // ------------------------------------------------------------------
    bit hold_req, hold_ack;
    int hold_cnt, stall_style, stall_span;

    always @(posedge aclk) begin
        if (hold_req != hold_ack) begin
            hold_ack <= hold_req;
            hold_cnt <= 700;
            m_ready  <= 1'b0;
        end else if (hold_cnt > 0) begin
            hold_cnt <= hold_cnt - 1;
            m_ready  <= 1'b0;
        end else begin
            if (stall_span == 0) begin
                stall_style <= $urandom_range(0, 3);
                stall_span  <= $urandom_range(16, 200);
            end else begin
                stall_span <= stall_span - 1;
            end
            case (stall_style)
                0: m_ready <= 1'b1;
                1: m_ready <= ($urandom_range(0, 1) == 0);
                2: m_ready <= ($urandom_range(0, 3) == 0);
                default: m_ready <= ($urandom_range(0, 7) != 0);
            endcase
        end
    end

    // Result checker: each accepted word against the oldest expectation
    always @(posedge aclk) begin
        eval_word_t w;
        if (aresetn && m_valid && m_ready) begin
            if (awaiting_results.size() == 0) begin
                $display("%0t: unexpected result word value %h interval %0d status %0d",
                         $time, m_result_value, m_interval_index, m_status);
                errors++;
            end else begin
                w = awaiting_results.pop_front();
                if (m_result_value !== w.value) begin
                    $display("%0t: result value expected %h got %h",
                             $time, w.value, m_result_value);
                    errors++;
                end
                if (m_interval_index !== w.interval) begin
                    $display("%0t: interval expected %0d got %0d",
                             $time, w.interval, m_interval_index);
                    errors++;
                end
                if (m_status !== w.status) begin
                    $display("%0t: status expected %0d got %0d", $time, w.status, m_status);
                    errors++;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // empty table in both modes; no table read happens
    task automatic test_empty;
        send_eval($urandom);
        write_reg(REG_EVAL_MODE, 1);
        send_eval($urandom);
        write_reg(REG_EVAL_MODE, 0);
    endtask

    // one entry: exact key gives its value, either side is out of range
    task automatic test_single;
        send_write(0, 3 * ONE_Q16, -7 * ONE_Q16);
        write_reg(REG_ENTRY_COUNT, 1);
        send_eval(3 * ONE_Q16);
        send_eval(3 * ONE_Q16 - 1);
        send_eval(3 * ONE_Q16 + 1);
    endtask

    // four entries, a zero-width interval in the middle
    task automatic test_linear;
        send_write(0, ONE_Q16, 10 * ONE_Q16);
        send_write(1, 2 * ONE_Q16, 20 * ONE_Q16);
        send_write(2, 2 * ONE_Q16, 30 * ONE_Q16);
        send_write(3, 4 * ONE_Q16, -5 * ONE_Q16);
        write_reg(REG_ENTRY_COUNT, 4);
        send_eval(ONE_Q16);                 // first key
        send_eval(ONE_Q16 + ONE_Q16 / 2);   // mid interval
        send_eval(3 * ONE_Q16);
        send_eval(4 * ONE_Q16);             // last key, final interval; hint now high
        send_eval(ONE_Q16 / 2);             // below
        send_eval(5 * ONE_Q16);             // above
        send_eval(32'sh8000_0000);
        send_eval(32'sh7FFF_FFFF);
        write_reg(REG_USE_HINT, 0);
        send_eval(2 * ONE_Q16);             // equal keys, plain bisection
        write_reg(REG_USE_HINT, 1);
        write_reg(REG_ENTRY_COUNT, 2);      // hint beyond the last interval
        send_eval(ONE_Q16 + ONE_Q16 / 4);
    endtask

    // Horner over the first three keys as coefficients
    task automatic test_poly;
        write_reg(REG_ENTRY_COUNT, 3);
        write_reg(REG_EVAL_MODE, 1);
        send_eval(0);
        send_eval(ONE_Q16);
        send_eval(32'sh7FFF_FFFF);          // saturates
        send_eval(32'sh8000_0000);
        write_reg(REG_UNUSED, 9'h1FF);
        write_reg(REG_EVAL_MODE, 0);
    endtask

    // full table, count beyond depth, and a long Horner pass
    task automatic test_full_depth;
        fill_table(DEFAULT_TABLE_DEPTH, 0);
        write_reg(REG_ENTRY_COUNT, DEFAULT_TABLE_DEPTH);
        repeat (10) send_eval(pick_point(DEFAULT_TABLE_DEPTH));
        write_reg(REG_ENTRY_COUNT, 511);
        repeat (6) send_eval(pick_point(DEFAULT_TABLE_DEPTH));
        write_reg(REG_ENTRY_COUNT, 300);
        write_reg(REG_EVAL_MODE, 1);
        repeat (3) send_eval(pick_point(DEFAULT_TABLE_DEPTH));
        write_reg(REG_EVAL_MODE, 0);
    endtask

    // receiver holds off while the sender keeps offering words
    task automatic test_backpressure;
        drain();
        gaps_on = 0;
        hold_req <= ~hold_req;
        repeat (16) send_eval(pick_point(count_reg > 256 ? 256 : count_reg));
        drain();
        gaps_on = 1;
    endtask

    // one random setting: reload the table, then evaluate with some rewrites
    task automatic random_phase;
        int n, style, evals, i;
        bit poly;
        poly = ($urandom_range(0, 4) == 0);
        n = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : $urandom_range(2, 16);
        if (!poly && $urandom_range(0, 9) == 0) n = $urandom_range(17, 64);
        style = poly ? 3 : (($urandom_range(0, 5) == 0) ? 2 : $urandom_range(0, 1));
        write_reg(REG_EVAL_MODE, 0);
        fill_table(n, style);
        write_reg(REG_ENTRY_COUNT, n);
        write_reg(REG_USE_HINT, ($urandom_range(0, 3) != 0));
        write_reg(REG_EVAL_MODE, poly);
        evals = $urandom_range(10, 50);
        repeat (evals) begin
            if ($urandom_range(0, 9) == 0) begin
                // rewrite one live slot, or touch one beyond the count
                i = $urandom_range(0, 255);
                if (i < n) send_write(i, key_mem[i], $urandom);
                else send_write(i, $urandom, $urandom);
            end else begin
                send_eval(pick_point(n));
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Run
    // ------------------------------------------------------------------
    initial begin
        errors        = 0;
        items_sent    = 0;
        burst_left    = 0;
        gaps_on       = 1;
        hint_interval = 0;
        poly_mode     = 1'b0;
        count_reg     = 0;
        hint_on       = 1'b1;
        hold_req      = 1'b0;
        hold_ack      = 1'b0;
        hold_cnt      = 0;
        stall_style   = 0;
        stall_span    = 0;
        aresetn       <= 1'b0;
        s_valid       <= 1'b0;
        s_command     <= CMD_WRITE;
        s_entry_index <= '0;
        s_entry_key   <= '0;
        s_entry_value <= '0;
        s_query_point <= '0;
        m_ready       <= 1'b0;
        cfg_valid     <= 1'b0;
        cfg_index     <= REG_EVAL_MODE;
        cfg_data      <= '0;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_empty();
        test_single();
        test_linear();
        test_poly();
        test_full_depth();
        test_backpressure();
        while (items_sent < NUM_ITEMS) random_phase();

        // let everything settle, then give the verdict
        s_valid <= 1'b0;
        while (awaiting_results.size() != 0) @(posedge aclk);
        repeat (100) @(posedge aclk);
        if (errors == 0 && awaiting_results.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    // watchdog
    initial begin
        #50_000_000;
        $display("Some tests failed");
        $finish;
    end

endmodule
